/* hdl/lbs_pkg.sv */
// lbs_pkg: shared types and fixed constants for the packed index lower-bound search.
// Chunk layout constants, error codes, sequencer states and the chunk status struct.
// No dependencies.
package lbs_pkg;

    localparam int HDR_BYTES   = 8;
    localparam int HDR_W       = 4;
    localparam int ENTRY_W     = 24;
    localparam int OFFSET_W    = 23;
    localparam int FLAG_BIT    = 23;
    localparam int VALUE_W     = 64;
    localparam int ASM_W       = 16;
    localparam int PHASE_W     = 2;

    localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_ALIGN = 2'd2,
        ERR_LONG  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_FETCH,
        S_EMIT
    } state_t;

    typedef struct packed {
        err_t               err;
        logic [VALUE_W-1:0] base;
    } chunk_info_t;

endpackage

/* hdl/lbs_if.sv */
// lbs_if: valid/ready channel interfaces for search requests and results.
// Depends on nothing; field widths follow the chunk and result formats.
interface lbs_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  chunk_byte;
    logic        last;
    logic [63:0] target;

    modport source (output valid, kind, chunk_byte, last, target, input ready);
    modport sink   (input valid, kind, chunk_byte, last, target, output ready);
endinterface

interface lbs_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_value;
    logic        match_flag;
    logic [1:0]  error;

    modport source (output valid, found, match_value, match_flag, error, input ready);
    modport sink   (input valid, found, match_value, match_flag, error, output ready);
endinterface

/* hdl/lbs_ram.sv */
// lbs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/lbs_cmp.sv */
// lbs_cmp: shared 64-bit add and compare unit used by every probe of the search.
// Depends on lbs_pkg.
module lbs_cmp (
    input  logic [lbs_pkg::VALUE_W-1:0]  base,
    input  logic [lbs_pkg::OFFSET_W-1:0] offset,
    input  logic [lbs_pkg::VALUE_W-1:0]  target,
    output logic [lbs_pkg::VALUE_W-1:0]  sum,
    output logic                         below
);
    import lbs_pkg::*;

    // Wrap at 64 bits, then compare unsigned.
    assign sum   = base + {{(VALUE_W-OFFSET_W){1'b0}}, offset};
    assign below = (sum < target);

endmodule

/* hdl/lbs_loader.sv */
// lbs_loader: assembles chunk bytes into the base value and 24-bit entries.
// Writes entries into the entry RAM and reports chunk status; depends on lbs_pkg.
module lbs_loader #(
    parameter int MAX_ENTRIES = 1024,
    parameter int CNT_W       = 11,
    parameter int IDX_W       = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_en,
    input  logic [7:0]                   data_byte,
    input  logic                         last,
    output lbs_pkg::chunk_info_t         info,
    output logic [CNT_W-1:0]             n,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output logic [lbs_pkg::ENTRY_W-1:0]  wr_data
);
    import lbs_pkg::*;

    logic [HDR_W-1:0]   hdr_reg,    hdr_next;
    logic [PHASE_W-1:0] phase_reg,  phase_next;
    logic [CNT_W-1:0]   cnt_reg,    cnt_next;
    logic [ASM_W-1:0]   asm_reg,    asm_next;
    logic [VALUE_W-1:0] base_reg,   base_next;
    logic               closed_reg, closed_next;
    logic               ovf_reg,    ovf_next;

    // View of the state after the new-chunk clear.
    logic [HDR_W-1:0]   eff_hdr;
    logic [PHASE_W-1:0] eff_phase;
    logic [CNT_W-1:0]   eff_cnt;
    logic [ASM_W-1:0]   eff_asm;
    logic [VALUE_W-1:0] eff_base;
    logic               eff_ovf;
    logic               full;

    always_comb
    begin
        eff_hdr   = closed_reg ? '0 : hdr_reg;
        eff_phase = closed_reg ? '0 : phase_reg;
        eff_cnt   = closed_reg ? '0 : cnt_reg;
        eff_asm   = closed_reg ? '0 : asm_reg;
        eff_base  = closed_reg ? '0 : base_reg;
        eff_ovf   = closed_reg ? 1'b0 : ovf_reg;
        full      = (eff_hdr == HDR_W'(HDR_BYTES)) && (eff_cnt == CNT_W'(MAX_ENTRIES));
    end

    always_comb
    begin
        hdr_next    = hdr_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        asm_next    = asm_reg;
        base_next   = base_reg;
        closed_next = closed_reg;
        ovf_next    = ovf_reg;
        wr_en       = 1'b0;
        wr_addr     = eff_cnt[IDX_W-1:0];
        wr_data     = {eff_asm, data_byte};
        if (byte_en)
        begin
            hdr_next    = eff_hdr;
            phase_next  = eff_phase;
            cnt_next    = eff_cnt;
            asm_next    = eff_asm;
            base_next   = eff_base;
            ovf_next    = eff_ovf;
            closed_next = last;
            if (full)
            begin
                // Drop the byte past capacity.
                ovf_next = 1'b1;
            end
            else if (eff_hdr < HDR_W'(HDR_BYTES))
            begin
                base_next = {eff_base[VALUE_W-9:0], data_byte};
                hdr_next  = eff_hdr + HDR_W'(1);
            end
            else if (eff_phase != PHASE_LAST)
            begin
                asm_next   = {eff_asm[7:0], data_byte};
                phase_next = eff_phase + PHASE_W'(1);
            end
            else
            begin
                wr_en      = 1'b1;
                phase_next = '0;
                cnt_next   = eff_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg    <= '0;
            phase_reg  <= '0;
            cnt_reg    <= '0;
            asm_reg    <= '0;
            base_reg   <= '0;
            closed_reg <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            hdr_reg    <= hdr_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            asm_reg    <= asm_next;
            base_reg   <= base_next;
            closed_reg <= closed_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_comb
    begin
        info.base = base_reg;
        if (ovf_reg)
        begin
            info.err = ERR_LONG;
        end
        else if (hdr_reg < HDR_W'(HDR_BYTES))
        begin
            info.err = ERR_SHORT;
        end
        else if (phase_reg != '0)
        begin
            info.err = ERR_ALIGN;
        end
        else
        begin
            info.err = ERR_NONE;
        end
    end

    assign n = cnt_reg;

endmodule

/* hdl/lbs_search.sv */
// lbs_search: lower-bound binary search sequencer driving the shared compare unit.
// Owns the result register; depends on lbs_pkg, lbs_if and lbs_cmp.
module lbs_search #(
    parameter int CNT_W = 11,
    parameter int IDX_W = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lbs_pkg::VALUE_W-1:0]  target,
    input  lbs_pkg::chunk_info_t         info,
    input  logic [CNT_W-1:0]             n,
    output logic                         idle,
    output logic                         rd_en,
    output logic [IDX_W-1:0]             rd_addr,
    input  logic [lbs_pkg::ENTRY_W-1:0]  rd_data,
    lbs_rsp_if.source                    rsp
);
    import lbs_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   first_reg, first_next;
    logic [CNT_W-1:0]   len_reg,   len_next;
    logic [CNT_W-1:0]   n_reg,     n_next;
    logic [VALUE_W-1:0] target_reg, target_next;
    err_t               err_reg,   err_next;
    logic               hit_reg,   hit_next;

    logic               valid_reg, valid_next;
    logic               found_reg, found_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               flag_reg,  flag_next;
    err_t               rerr_reg,  rerr_next;

    logic [CNT_W-1:0]   half;
    logic [CNT_W-1:0]   mid;
    logic [VALUE_W-1:0] sum;
    logic               below;
    logic               out_free;

    assign half     = len_reg >> 1;
    assign mid      = first_reg + half;
    assign out_free = !valid_reg || rsp.ready;

    lbs_cmp u_cmp (
        .base   (info.base),
        .offset (rd_data[OFFSET_W-1:0]),
        .target (target_reg),
        .sum    (sum),
        .below  (below)
    );

    // Search bookkeeping.
    always_comb
    begin
        first_next  = first_reg;
        len_next    = len_reg;
        n_next      = n_reg;
        target_next = target_reg;
        err_next    = err_reg;
        hit_next    = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    first_next  = '0;
                    len_next    = n;
                    n_next      = n;
                    target_next = target;
                    err_next    = info.err;
                    hit_next    = 1'b0;
                end
            end
            S_CMP:
            begin
                if (below)
                begin
                    first_next = mid + CNT_W'(1);
                    len_next   = len_reg - half - CNT_W'(1);
                end
                else
                begin
                    len_next = half;
                end
            end
            S_FETCH:
            begin
                hit_next = 1'b1;
            end
            default:
            begin
                first_next = first_reg;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((info.err != ERR_NONE) || (n == '0))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (len_next != '0)
                begin
                    state_next = S_PROBE;
                end
                else if (first_next < n_reg)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs: memory read port and result register.
    always_comb
    begin
        idle       = (state_reg == S_IDLE);
        rd_en      = (state_reg == S_PROBE) || (state_reg == S_FETCH);
        rd_addr    = (state_reg == S_PROBE) ? mid[IDX_W-1:0] : first_reg[IDX_W-1:0];
        valid_next = valid_reg;
        found_next = found_reg;
        value_next = value_reg;
        flag_next  = flag_reg;
        rerr_next  = rerr_reg;
        if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        if ((state_reg == S_EMIT) && out_free)
        begin
            // Read data holds since the port is idle in this state.
            valid_next = 1'b1;
            found_next = hit_reg;
            value_next = hit_reg ? sum : '0;
            flag_next  = hit_reg ? rd_data[FLAG_BIT] : 1'b0;
            rerr_next  = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        len_reg    <= len_next;
        n_reg      <= n_next;
        target_reg <= target_next;
        err_reg    <= err_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        value_reg  <= value_next;
        flag_reg   <= flag_next;
        rerr_reg   <= rerr_next;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.match_value = value_reg;
    assign rsp.match_flag  = flag_reg;
    assign rsp.error       = rerr_reg;

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (mid < n_reg))
        else $error("probe index beyond entry count");

    a_cmp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (len_reg != '0))
        else $error("compare step with empty range");

    a_first_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_EMIT) |-> (first_reg <= n_reg))
        else $error("lower bound moved past entry count");

    a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && found_reg) |-> (rerr_reg == ERR_NONE))
        else $error("hit reported together with an error code");

endmodule

/* hdl/packed_index_lower_bound_search_core.sv */
// Packed index lower-bound search core: loads a chunk byte by byte, then searches it.
// Chunk bytes: one transaction per cycle while no search is in flight, no result. Search:
// each probe has a read state and a compare state, for the registered RAM read.
// The result is registered as the request side turns ready again; a full result stalls it.
// Reset (rst_n, async, active low) empties the chunk; entry RAM contents are not cleared.
// Depends on lbs_pkg, lbs_if, lbs_ram, lbs_cmp, lbs_loader and lbs_search.
module packed_index_lower_bound_search_core #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    lbs_req_if.sink   req,
    lbs_rsp_if.source rsp
);
    import lbs_pkg::*;

    // Entry count must hold MAX_ENTRIES itself; the RAM index covers 0..MAX_ENTRIES-1.
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic                 accept;
    logic                 byte_en;
    logic                 start;
    logic                 idle;
    chunk_info_t          info;
    logic [CNT_W-1:0]     n;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]   rd_data;

    // A transaction is taken only while no search is in flight; the loader and the
    // sequencer therefore never touch the entry RAM in the same cycle.
    assign req.ready = idle;
    assign accept    = req.valid && req.ready;
    assign byte_en   = accept && (req.kind == KIND_BYTE);
    assign start     = accept && (req.kind == KIND_SEARCH);

    // Byte assembly: header shifts into the base value, every third entry byte
    // commits a 24-bit entry. Status is the error code seen by the next search.
    lbs_loader #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_loader (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (req.chunk_byte),
        .last      (req.last),
        .info      (info),
        .n         (n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Entry store: one write port for the loader, one registered read port for probes and the final fetch.
    lbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Binary search: each probe reads the middle entry, then the shared add/compare
    // unit decides which half to keep. A final read fetches the lower-bound entry.
    lbs_search #(
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .target  (req.target),
        .info    (info),
        .n       (n),
        .idle    (idle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (rsp)
    );

endmodule
